@@ rtl/decimal_accumulator_machine_step_core_defines.svh @@
// ----------------------------------------------------------------------------
// Decimal accumulator machine assertion macros
// Concurrent assertion wrappers that drop out of synthesis builds.
// ----------------------------------------------------------------------------
`ifndef DECIMAL_ACCUMULATOR_MACHINE_STEP_CORE_DEFINES_SVH
`define DECIMAL_ACCUMULATOR_MACHINE_STEP_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define DACM_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define DACM_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define DACM_ASSERT_IMP(name, clk, rst, ante, cons)
`define DACM_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif

`endif

@@ rtl/dacm_pkg.sv @@
// ----------------------------------------------------------------------------
// Decimal accumulator machine package
// Widths, command, opcode and status codes, and the sequencer state type.
// ----------------------------------------------------------------------------
package dacm_pkg;

   localparam int MEM_WORDS     = 100;
   localparam int WORD_BITS_DEF = 32;
   localparam int ADDR_BITS     = 7;
   localparam int IO_BITS       = 32;
   localparam int OP_BITS       = 2;
   localparam int STATUS_BITS   = 3;
   localparam int CODE_BITS     = 6;

   localparam int LOW_BITS      = 13;
   localparam int PROD_BITS     = 26;
   localparam int DIV100_RECIP  = 5243;
   localparam int DIV100_SHIFT  = 19;
   localparam int OPC_SCALE     = 100;
   localparam int INSTR_LIMIT   = 4400;

   localparam logic signed [IO_BITS-1:0] LOAD_MAX = 32'sd9999;

   localparam logic [OP_BITS-1:0] CMD_LOAD = 2'd0;
   localparam logic [OP_BITS-1:0] CMD_EXEC = 2'd1;
   localparam logic [OP_BITS-1:0] CMD_READ = 2'd2;

   localparam logic [CODE_BITS-1:0] OPC_READ   = 6'd10;
   localparam logic [CODE_BITS-1:0] OPC_WRITE  = 6'd11;
   localparam logic [CODE_BITS-1:0] OPC_LOAD   = 6'd20;
   localparam logic [CODE_BITS-1:0] OPC_STORE  = 6'd21;
   localparam logic [CODE_BITS-1:0] OPC_ADD    = 6'd30;
   localparam logic [CODE_BITS-1:0] OPC_SUB    = 6'd31;
   localparam logic [CODE_BITS-1:0] OPC_DIV    = 6'd32;
   localparam logic [CODE_BITS-1:0] OPC_MUL    = 6'd33;
   localparam logic [CODE_BITS-1:0] OPC_BR     = 6'd40;
   localparam logic [CODE_BITS-1:0] OPC_BRNEG  = 6'd41;
   localparam logic [CODE_BITS-1:0] OPC_BRZERO = 6'd42;
   localparam logic [CODE_BITS-1:0] OPC_HALT   = 6'd43;

   localparam logic [STATUS_BITS-1:0] ST_OK      = 3'd0;
   localparam logic [STATUS_BITS-1:0] ST_HALT    = 3'd1;
   localparam logic [STATUS_BITS-1:0] ST_END     = 3'd2;
   localparam logic [STATUS_BITS-1:0] ST_INVALID = 3'd3;
   localparam logic [STATUS_BITS-1:0] ST_DIVZERO = 3'd4;
   localparam logic [STATUS_BITS-1:0] ST_STOPPED = 3'd5;
   localparam logic [STATUS_BITS-1:0] ST_REJECT  = 3'd6;

   typedef enum logic [7:0] {
      S_IDLE   = 8'b0000_0001,
      S_RDATA  = 8'b0000_0010,
      S_DECODE = 8'b0000_0100,
      S_SPLIT  = 8'b0000_1000,
      S_EXEC   = 8'b0001_0000,
      S_DPREP  = 8'b0010_0000,
      S_ITER   = 8'b0100_0000,
      S_DFIX   = 8'b1000_0000
   } state_type;

endpackage

@@ rtl/decimal_accumulator_machine_step_core.sv @@
// ----------------------------------------------------------------------------
// Decimal accumulator machine step core
// Loads program words, reads memory words back and executes one instruction
// per item on a small accumulator machine with a hundred-word memory.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low, and its single result
// appears for one cycle with rsp_valid high; the result cannot be held off, so
// it must be captured in that cycle. A load, or an unused command, gives its
// result in the cycle after it is taken and leaves busy low. A memory read
// passes mem_q_ff and S_RDATA. An instruction goes through S_DECODE, S_SPLIT
// and S_EXEC; a zero word, a negative word or an out-of-range code ends it in
// S_DECODE, and it is answered in S_IDLE when the machine is stopped or the
// counter has run past memory. Multiply (S_ITER) and divide (S_DPREP, S_ITER,
// S_DFIX) iterate one bit per cycle through the single shared adder. A new
// item may be started in the cycle in which the previous result is shown.
`include "decimal_accumulator_machine_step_core_defines.svh"

module decimal_accumulator_machine_step_core #(
   parameter int WORD_BITS = dacm_pkg::WORD_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [dacm_pkg::OP_BITS-1:0]      req_op,
   input  logic [dacm_pkg::ADDR_BITS-1:0]    req_address,
   input  logic signed [dacm_pkg::IO_BITS-1:0] req_value,
   input  logic signed [dacm_pkg::IO_BITS-1:0] req_read_value,
   output logic                              rsp_valid,
   output logic [dacm_pkg::STATUS_BITS-1:0]  rsp_status,
   output logic [dacm_pkg::ADDR_BITS-1:0]    rsp_program_counter,
   output logic signed [dacm_pkg::IO_BITS-1:0] rsp_accumulator_out,
   output logic                              rsp_print_valid,
   output logic [dacm_pkg::ADDR_BITS-1:0]    rsp_print_address,
   output logic signed [dacm_pkg::IO_BITS-1:0] rsp_print_value,
   output logic signed [dacm_pkg::IO_BITS-1:0] rsp_read_data
);
   import dacm_pkg::*;

   localparam int CNT_BITS = $clog2(WORD_BITS);
   localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(WORD_BITS - 1);

   function automatic logic [WORD_BITS-1:0] to_word(input logic [IO_BITS-1:0] x);
      logic signed [63:0] ext;
      ext = 64'(signed'(x));
      return ext[WORD_BITS-1:0];
   endfunction

   function automatic logic [IO_BITS-1:0] to_out(input logic [WORD_BITS-1:0] x);
      logic signed [63:0] ext;
      ext = 64'(signed'(x));
      return ext[IO_BITS-1:0];
   endfunction

   state_type state_ff, state_in;
   logic [ADDR_BITS-1:0]   pc_ff, pc_in;
   logic [WORD_BITS-1:0]   acc_ff, acc_in;
   logic                   stopped_ff, stopped_in;
   logic [CNT_BITS-1:0]    cnt_ff, cnt_in;
   logic                   mul_ff, mul_in;
   logic                   sign_ff, sign_in;
   logic [WORD_BITS-1:0]   work_a_ff, work_a_in;
   logic [WORD_BITS-1:0]   work_b_ff, work_b_in;
   logic [WORD_BITS-1:0]   work_c_ff, work_c_in;
   logic [CODE_BITS-1:0]   code_ff, code_in;
   logic [LOW_BITS-1:0]    w_lo_ff, w_lo_in;
   logic [ADDR_BITS-1:0]   addr_ff, addr_in;
   logic [IO_BITS-1:0]     rv_ff, rv_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [STATUS_BITS-1:0] status_ff, status_in;
   logic                   print_valid_ff, print_valid_in;
   logic [ADDR_BITS-1:0]   print_addr_ff, print_addr_in;
   logic [IO_BITS-1:0]     print_value_ff, print_value_in;
   logic [IO_BITS-1:0]     read_data_ff, read_data_in;

   logic [WORD_BITS-1:0]   mem_ff [MEM_WORDS];
   logic [MEM_WORDS-1:0]   valid_ff;
   logic [WORD_BITS-1:0]   mem_q_ff;
   logic                   mem_we;
   logic [ADDR_BITS-1:0]   mem_waddr;
   logic [WORD_BITS-1:0]   mem_wdata;
   logic [ADDR_BITS-1:0]   mem_raddr;

   logic [WORD_BITS-1:0]   alu_a;
   logic [WORD_BITS-1:0]   alu_b;
   logic                   alu_sub;
   logic [WORD_BITS:0]     alu_sum;

   logic [PROD_BITS-1:0]   prod;
   logic [LOW_BITS-1:0]    split;
   logic [WORD_BITS-1:0]   shifted;
   logic [ADDR_BITS-1:0]   next_pc;
   logic                   load_ok;

   assign alu_sum = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)}
                  + (WORD_BITS + 1)'(alu_sub);

   assign prod    = PROD_BITS'(mem_q_ff[LOW_BITS-1:0]) * PROD_BITS'(DIV100_RECIP);
   assign split   = w_lo_ff - LOW_BITS'(LOW_BITS'(code_ff) * LOW_BITS'(OPC_SCALE));
   assign shifted = {work_a_ff[WORD_BITS-2:0], work_b_ff[WORD_BITS-1]};
   assign next_pc = ADDR_BITS'(pc_ff + ADDR_BITS'(1));
   assign load_ok = ($signed(req_value) >= -LOAD_MAX) && ($signed(req_value) <= LOAD_MAX)
                  && (req_address < ADDR_BITS'(MEM_WORDS));

   always_comb begin
      state_in       = state_ff;
      pc_in          = pc_ff;
      acc_in         = acc_ff;
      stopped_in     = stopped_ff;
      cnt_in         = cnt_ff;
      mul_in         = mul_ff;
      sign_in        = sign_ff;
      work_a_in      = work_a_ff;
      work_b_in      = work_b_ff;
      work_c_in      = work_c_ff;
      code_in        = code_ff;
      w_lo_in        = w_lo_ff;
      addr_in        = addr_ff;
      rv_in          = rv_ff;
      rsp_valid_in   = 1'b0;
      status_in      = ST_OK;
      print_valid_in = 1'b0;
      print_addr_in  = '0;
      print_value_in = '0;
      read_data_in   = '0;
      mem_we         = 1'b0;
      mem_waddr      = addr_ff;
      mem_wdata      = acc_ff;
      mem_raddr      = pc_ff;
      alu_a          = '0;
      alu_b          = '0;
      alu_sub        = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               rv_in = req_read_value;
               case (req_op)
                  CMD_LOAD: begin
                     rsp_valid_in = 1'b1;
                     if (load_ok) begin
                        mem_we    = 1'b1;
                        mem_waddr = req_address;
                        mem_wdata = to_word(req_value);
                     end else begin
                        status_in = ST_REJECT;
                     end
                  end
                  CMD_EXEC: begin
                     if (stopped_ff) begin
                        rsp_valid_in = 1'b1;
                        status_in    = ST_STOPPED;
                     end else if (pc_ff >= ADDR_BITS'(MEM_WORDS)) begin
                        rsp_valid_in = 1'b1;
                        status_in    = ST_END;
                        stopped_in   = 1'b1;
                     end else begin
                        state_in = S_DECODE;
                     end
                  end
                  CMD_READ: begin
                     mem_raddr = req_address;
                     state_in  = S_RDATA;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         S_RDATA: begin
            rsp_valid_in = 1'b1;
            read_data_in = to_out(mem_q_ff);
            state_in     = S_IDLE;
         end
         S_DECODE: begin
            w_lo_in = mem_q_ff[LOW_BITS-1:0];
            code_in = prod[DIV100_SHIFT +: CODE_BITS];
            if (mem_q_ff == '0) begin
               rsp_valid_in = 1'b1;
               status_in    = ST_END;
               stopped_in   = 1'b1;
               state_in     = S_IDLE;
            end else if (mem_q_ff[WORD_BITS-1]
                         || (mem_q_ff >= WORD_BITS'(INSTR_LIMIT))) begin
               rsp_valid_in = 1'b1;
               status_in    = ST_INVALID;
               stopped_in   = 1'b1;
               state_in     = S_IDLE;
            end else begin
               state_in = S_SPLIT;
            end
         end
         S_SPLIT: begin
            addr_in   = split[ADDR_BITS-1:0];
            mem_raddr = split[ADDR_BITS-1:0];
            state_in  = S_EXEC;
         end
         S_EXEC: begin
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
            case (code_ff)
               OPC_READ: begin
                  mem_we    = 1'b1;
                  mem_wdata = to_word(rv_ff);
                  pc_in     = next_pc;
               end
               OPC_WRITE: begin
                  print_valid_in = 1'b1;
                  print_addr_in  = addr_ff;
                  print_value_in = to_out(mem_q_ff);
                  pc_in          = next_pc;
               end
               OPC_LOAD: begin
                  acc_in = mem_q_ff;
                  pc_in  = next_pc;
               end
               OPC_STORE: begin
                  mem_we = 1'b1;
                  pc_in  = next_pc;
               end
               OPC_ADD, OPC_SUB: begin
                  alu_a   = acc_ff;
                  alu_b   = mem_q_ff;
                  alu_sub = (code_ff == OPC_SUB);
                  acc_in  = alu_sum[WORD_BITS-1:0];
                  pc_in   = next_pc;
               end
               OPC_DIV: begin
                  if (mem_q_ff == '0) begin
                     status_in  = ST_DIVZERO;
                     stopped_in = 1'b1;
                  end else begin
                     rsp_valid_in = 1'b0;
                     alu_b        = acc_ff;
                     alu_sub      = 1'b1;
                     work_b_in    = acc_ff[WORD_BITS-1] ? alu_sum[WORD_BITS-1:0] : acc_ff;
                     work_c_in    = mem_q_ff;
                     sign_in      = acc_ff[WORD_BITS-1] ^ mem_q_ff[WORD_BITS-1];
                     state_in     = S_DPREP;
                  end
               end
               OPC_MUL: begin
                  rsp_valid_in = 1'b0;
                  work_a_in    = '0;
                  work_b_in    = mem_q_ff;
                  work_c_in    = acc_ff;
                  cnt_in       = '0;
                  mul_in       = 1'b1;
                  state_in     = S_ITER;
               end
               OPC_BR: begin
                  pc_in = addr_ff;
               end
               OPC_BRNEG: begin
                  pc_in = acc_ff[WORD_BITS-1] ? addr_ff : next_pc;
               end
               OPC_BRZERO: begin
                  pc_in = (acc_ff == '0) ? addr_ff : next_pc;
               end
               OPC_HALT: begin
                  status_in  = ST_HALT;
                  stopped_in = 1'b1;
               end
               default: begin
                  status_in  = ST_INVALID;
                  stopped_in = 1'b1;
               end
            endcase
         end
         S_DPREP: begin
            alu_b     = work_c_ff;
            alu_sub   = 1'b1;
            work_c_in = work_c_ff[WORD_BITS-1] ? alu_sum[WORD_BITS-1:0] : work_c_ff;
            work_a_in = '0;
            cnt_in    = '0;
            mul_in    = 1'b0;
            state_in  = S_ITER;
         end
         S_ITER: begin
            cnt_in = CNT_BITS'(cnt_ff + CNT_BITS'(1));
            if (mul_ff) begin
               alu_a     = work_a_ff;
               alu_b     = work_c_ff;
               work_a_in = work_b_ff[0] ? alu_sum[WORD_BITS-1:0] : work_a_ff;
               work_b_in = {1'b0, work_b_ff[WORD_BITS-1:1]};
               work_c_in = {work_c_ff[WORD_BITS-2:0], 1'b0};
               if (cnt_ff == CNT_LAST) begin
                  acc_in       = work_a_in;
                  pc_in        = next_pc;
                  rsp_valid_in = 1'b1;
                  state_in     = S_IDLE;
               end
            end else begin
               alu_a     = shifted;
               alu_b     = work_c_ff;
               alu_sub   = 1'b1;
               work_a_in = alu_sum[WORD_BITS] ? alu_sum[WORD_BITS-1:0] : shifted;
               work_b_in = {work_b_ff[WORD_BITS-2:0], alu_sum[WORD_BITS]};
               if (cnt_ff == CNT_LAST) begin
                  state_in = S_DFIX;
               end
            end
         end
         S_DFIX: begin
            alu_b        = work_b_ff;
            alu_sub      = 1'b1;
            acc_in       = sign_ff ? alu_sum[WORD_BITS-1:0] : work_b_ff;
            pc_in        = next_pc;
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pc_ff        <= '0;
         acc_ff       <= '0;
         stopped_ff   <= 1'b0;
         cnt_ff       <= '0;
         mul_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         valid_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         pc_ff        <= pc_in;
         acc_ff       <= acc_in;
         stopped_ff   <= stopped_in;
         cnt_ff       <= cnt_in;
         mul_ff       <= mul_in;
         rsp_valid_ff <= rsp_valid_in;
         if (mem_we) begin
            valid_ff[mem_waddr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      sign_ff        <= sign_in;
      work_a_ff      <= work_a_in;
      work_b_ff      <= work_b_in;
      work_c_ff      <= work_c_in;
      code_ff        <= code_in;
      w_lo_ff        <= w_lo_in;
      addr_ff        <= addr_in;
      rv_ff          <= rv_in;
      status_ff      <= status_in;
      print_valid_ff <= print_valid_in;
      print_addr_ff  <= print_addr_in;
      print_value_ff <= print_value_in;
      read_data_ff   <= read_data_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_ff[mem_waddr] <= mem_wdata;
      end
      if ((mem_raddr < ADDR_BITS'(MEM_WORDS)) && valid_ff[mem_raddr]) begin
         mem_q_ff <= mem_ff[mem_raddr];
      end else begin
         mem_q_ff <= '0;
      end
   end

   assign busy                = (state_ff != S_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = status_ff;
   assign rsp_program_counter = pc_ff;
   assign rsp_accumulator_out = to_out(acc_ff);
   assign rsp_print_valid     = print_valid_ff;
   assign rsp_print_address   = print_addr_ff;
   assign rsp_print_value     = print_value_ff;
   assign rsp_read_data       = read_data_ff;

   `DACM_ASSERT_NEXT(a_load_answers, clock, reset, start && !busy && (req_op == CMD_LOAD), rsp_valid)
   `DACM_ASSERT_IMP(a_rsp_when_idle, clock, reset, rsp_valid, state_ff == S_IDLE)
   `DACM_ASSERT_IMP(a_stop_reported, clock, reset, $rose(stopped_ff), rsp_valid)
   `DACM_ASSERT_IMP(a_pc_in_range, clock, reset, 1'b1, pc_ff <= ADDR_BITS'(MEM_WORDS))

endmodule
